@@ rtl/mme_pkg.sv @@
// Shared types and constants for the matrix multiply engine.
// Used by mme_mac and matrix_multiply_engine_top. No dependencies.
`timescale 1ns / 1ps

package mme_pkg;

   // Field and datapath widths
   localparam int ELEM_W    = 16;
   localparam int FRAC_BITS = 12;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 4;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = PROD_W + IDX_W;
   localparam int CSR_IDX_W = 2;

   // Saturation limits of a result element, at accumulator width
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (ELEM_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (ELEM_W - 1)));

   // Request codes
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_START  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS = 2'd3;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        elem_row;
      logic [IDX_W-1:0]        elem_col;
      logic signed [ELEM_W-1:0] elem_value;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic signed [ELEM_W-1:0] out_value;
      logic                    is_last;
      logic                    dim_error;
   } rsp_payload_type;

   // Control that travels with one operand pair into the MAC
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // Finished dot product from the MAC
   typedef struct packed {
      logic                    done;
      logic signed [ELEM_W-1:0] value;
   } mac_res_type;

endpackage

@@ rtl/matrix_multiply_engine_top.sv @@
// Matrix multiply engine, top level. Depends on mme_pkg and mme_mac.
// Loads are accepted back to back while idle.
// A start with matched dimensions issues one MAC per cycle from the two element
// memories for each result element, then waits for the sum and pushes it; output stalls can hold the push.
// A dimension mismatch gives its single error result through the error state.
// Synchronous reset clears control and sets all dimensions to 8; stores keep contents.
`timescale 1ns / 1ps

module matrix_multiply_engine_top #(
   parameter int MAX_DIM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mme_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mme_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mme_pkg::DIM_W-1:0]           csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX = mme_pkg::DIM_W'(MAX_DIM);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_ISSUE,
      ST_WAIT,
      ST_PUSH
   } state_type;

   state_type                          state_ff;
   logic [mme_pkg::DIM_W-1:0]          a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [mme_pkg::DIM_W-1:0]          ar_ff, ac_ff, bc_ff;
   logic [mme_pkg::IDX_W-1:0]          i_ff, j_ff, k_ff;
   mme_pkg::mac_ctl_type               issue_ff;
   logic                               rsp_valid_ff;
   mme_pkg::rsp_payload_type           rsp_data_ff;
   mme_pkg::rsp_payload_type           rsp_data_in;
   logic signed [mme_pkg::ELEM_W-1:0]  mem_a [DEPTH];
   logic signed [mme_pkg::ELEM_W-1:0]  mem_b [DEPTH];
   logic signed [mme_pkg::ELEM_W-1:0]  rd_a_ff, rd_b_ff;
   logic [AW-1:0]                      wr_addr, rd_addr_a, rd_addr_b;
   logic                               req_accept, load_ok, rsp_free, rsp_load;
   logic [mme_pkg::DIM_W-1:0]          ar_c, ac_c, br_c, bc_c;
   logic                               last_k, last_col, last_row;
   mme_pkg::mac_res_type               mac_res;

   // Dimension register as used: zero reads as one, above the maximum as the maximum.
   function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
      input logic [mme_pkg::DIM_W-1:0] d
   );
      logic [mme_pkg::DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = mme_pkg::DIM_W'(1);
      end else if (d > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   // Row-major element address
   function automatic logic [AW-1:0] elem_addr(
      input logic [mme_pkg::IDX_W-1:0] r,
      input logic [mme_pkg::IDX_W-1:0] c
   );
      return AW'(int'(r) * MAX_DIM + int'(c));
   endfunction

   // Handshake and control decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = rsp_free && ((state_ff == ST_ERR) || (state_ff == ST_PUSH));

   assign ar_c = clamp_dim(a_rows_ff);
   assign ac_c = clamp_dim(a_cols_ff);
   assign br_c = clamp_dim(b_rows_ff);
   assign bc_c = clamp_dim(b_cols_ff);

   assign last_k   = (mme_pkg::DIM_W'(k_ff) + 1'b1) == ac_ff;
   assign last_col = (mme_pkg::DIM_W'(j_ff) + 1'b1) == bc_ff;
   assign last_row = (mme_pkg::DIM_W'(i_ff) + 1'b1) == ar_ff;

   assign load_ok = (mme_pkg::DIM_W'(req_data.elem_row) < DIM_MAX)
                 && (mme_pkg::DIM_W'(req_data.elem_col) < DIM_MAX);

   assign wr_addr   = elem_addr(req_data.elem_row, req_data.elem_col);
   assign rd_addr_a = elem_addr(i_ff, k_ff);
   assign rd_addr_b = elem_addr(k_ff, j_ff);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= mme_pkg::DIM_RESET;
         a_cols_ff <= mme_pkg::DIM_RESET;
         b_rows_ff <= mme_pkg::DIM_RESET;
         b_cols_ff <= mme_pkg::DIM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mme_pkg::CSR_A_ROWS: a_rows_ff <= csr_wdata;
            mme_pkg::CSR_A_COLS: a_cols_ff <= csr_wdata;
            mme_pkg::CSR_B_ROWS: b_rows_ff <= csr_wdata;
            mme_pkg::CSR_B_COLS: b_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Element memories: one write port for loads, one registered read port each.
   always_ff @(posedge clock) begin
      if (req_accept && load_ok && (req_data.req_type == mme_pkg::REQ_LOAD_A)) begin
         mem_a[wr_addr] <= req_data.elem_value;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (req_accept && load_ok && (req_data.req_type == mme_pkg::REQ_LOAD_B)) begin
         mem_b[wr_addr] <= req_data.elem_value;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   // Dot product unit; its control is registered, like the read data, so the two arrive together.
   mme_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (issue_ff),
      .opnd_a (rd_a_ff),
      .opnd_b (rd_b_ff),
      .res    (mac_res)
   );

   // Sequencer over rows, columns and the inner dimension
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         ar_ff        <= mme_pkg::DIM_RESET;
         ac_ff        <= mme_pkg::DIM_RESET;
         bc_ff        <= mme_pkg::DIM_RESET;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // One operand pair goes to the MAC in every issue cycle.
         issue_ff.valid <= (state_ff == ST_ISSUE);
         issue_ff.first <= (k_ff == '0);
         issue_ff.last  <= last_k;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_data.req_type == mme_pkg::REQ_START)) begin
                  ar_ff <= ar_c;
                  ac_ff <= ac_c;
                  bc_ff <= bc_c;
                  i_ff  <= '0;
                  j_ff  <= '0;
                  k_ff  <= '0;
                  state_ff <= (br_c != ac_c) ? ST_ERR : ST_ISSUE;
               end
            end
            ST_ERR: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_ISSUE: begin
               if (last_k) begin
                  k_ff     <= '0;
                  state_ff <= ST_WAIT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (mac_res.done) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (rsp_free) begin
                  if (last_col) begin
                     j_ff <= '0;
                     if (last_row) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= ST_ISSUE;
                     end
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Result transaction contents
   always_comb begin
      rsp_data_in = '0;
      if (state_ff == ST_ERR) begin
         rsp_data_in.is_last   = 1'b1;
         rsp_data_in.dim_error = 1'b1;
      end else begin
         rsp_data_in.out_row   = i_ff;
         rsp_data_in.out_col   = j_ff;
         rsp_data_in.out_value = mac_res.value;
         rsp_data_in.is_last   = last_row && last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // A finished sum only appears while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mac_res.done |-> (state_ff == ST_WAIT))
      else $error("dot product finished outside the wait state");

   // The inner index never runs past the inner dimension.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (mme_pkg::DIM_W'(k_ff) < ac_ff))
      else $error("inner index beyond inner dimension");

   // A matched start begins issuing at the first element.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_data.req_type == mme_pkg::REQ_START) && (br_c == ac_c))
      |=> (state_ff == ST_ISSUE) && (i_ff == '0) && (j_ff == '0) && (k_ff == '0))
      else $error("matched start did not begin at element zero");

   // Nothing is issued to the MAC while a result waits to be pushed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> !issue_ff.valid)
      else $error("MAC issue during result push");
`endif

endmodule

@@ rtl/mme_mac.sv @@
// Multiply-accumulate unit: registered product, full-width accumulator,
// then shift by the fraction bits and saturation. Depends on mme_pkg.
`timescale 1ns / 1ps

module mme_mac (
   input  logic                            clock,
   input  logic                            reset,
   input  mme_pkg::mac_ctl_type            ctl,
   input  logic signed [mme_pkg::ELEM_W-1:0] opnd_a,
   input  logic signed [mme_pkg::ELEM_W-1:0] opnd_b,
   output mme_pkg::mac_res_type            res
);

   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   mme_pkg::mac_ctl_type              ctl1_ff;
   logic signed [mme_pkg::ACC_W-1:0]  acc_ff;
   logic                              done_ff;
   logic signed [mme_pkg::ACC_W-1:0]  scaled;

   // Control pipeline alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl1_ff <= ctl;
         done_ff <= ctl1_ff.valid && ctl1_ff.last;
      end
   end

   // Product stage, then accumulate; the first term of a sum restarts it.
   always_ff @(posedge clock) begin
      prod_ff <= opnd_a * opnd_b;
      if (ctl1_ff.valid) begin
         if (ctl1_ff.first) begin
            acc_ff <= mme_pkg::ACC_W'(prod_ff);
         end else begin
            acc_ff <= acc_ff + mme_pkg::ACC_W'(prod_ff);
         end
      end
   end

   // Arithmetic shift rounds toward minus infinity; then clip to the element range.
   always_comb begin
      scaled    = acc_ff >>> mme_pkg::FRAC_BITS;
      res.done  = done_ff;
      if (scaled > mme_pkg::SAT_HI) begin
         res.value = mme_pkg::SAT_HI[mme_pkg::ELEM_W-1:0];
      end else if (scaled < mme_pkg::SAT_LO) begin
         res.value = mme_pkg::SAT_LO[mme_pkg::ELEM_W-1:0];
      end else begin
         res.value = scaled[mme_pkg::ELEM_W-1:0];
      end
   end

endmodule

@@ tb/sv/matrix_product_checker.sv @@
// Checker for the matrix multiply engine: watches the request, result and register
// channels, predicts every product element and compares it. Depends on mme_pkg.
`timescale 1ns / 1ps

module matrix_product_checker
   import mme_pkg::*;
#(
   parameter int MAX_DIM = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   output int              fail_count,
   output int              pending_count,
   output int              product_count,
   output int              dim_error_count
);

   localparam longint ELEM_MAX = (longint'(1) <<< (ELEM_W - 1)) - 1;
   localparam longint ELEM_MIN = -ELEM_MAX - 1;
   localparam int REPORT_LIMIT = 10;

   // Shadow copies of both element stores and the four dimension registers
   logic signed [ELEM_W-1:0] a_elems [MAX_DIM*MAX_DIM];
   logic signed [ELEM_W-1:0] b_elems [MAX_DIM*MAX_DIM];
   logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

   // Product elements still owed by the block, oldest first
   rsp_payload_type owed_products [$];
   int reported;

   // A register value of zero acts as one, anything above the maximum as the maximum.
   function automatic int effective_dim(input logic [DIM_W-1:0] d);
      if (d == '0)
         return 1;
      if (int'(d) > MAX_DIM)
         return MAX_DIM;
      return int'(d);
   endfunction

   // Drop the fraction bits (floor) and clip to the element range.
   function automatic logic signed [ELEM_W-1:0] scale_to_elem(input longint sum);
      longint q;
      q = sum >>> FRAC_BITS;
      if (q > ELEM_MAX)
         q = ELEM_MAX;
      if (q < ELEM_MIN)
         q = ELEM_MIN;
      return q[ELEM_W-1:0];
   endfunction

   // Work out every result that one start transaction causes.
   task automatic predict_product();
      int ar, ac, br, bc;
      longint acc;
      rsp_payload_type elem;
      ar = effective_dim(a_rows_reg);
      ac = effective_dim(a_cols_reg);
      br = effective_dim(b_rows_reg);
      bc = effective_dim(b_cols_reg);
      if (br != ac) begin
         elem = '0;
         elem.is_last = 1'b1;
         elem.dim_error = 1'b1;
         owed_products.push_back(elem);
         return;
      end
      for (int i = 0; i < ar; i++) begin
         for (int j = 0; j < bc; j++) begin
            acc = 0;
            for (int k = 0; k < ac; k++)
               acc += longint'(a_elems[i*MAX_DIM+k]) * longint'(b_elems[k*MAX_DIM+j]);
            elem.out_row = IDX_W'(i);
            elem.out_col = IDX_W'(j);
            elem.out_value = scale_to_elem(acc);
            elem.is_last = (i == ar - 1) && (j == bc - 1);
            elem.dim_error = 1'b0;
            owed_products.push_back(elem);
         end
      end
   endtask

   // Compare one accepted result against the oldest owed element.
   task automatic compare_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (got.dim_error === 1'b1)
         dim_error_count++;
      else
         product_count++;
      if (owed_products.size() == 0) begin
         fail_count++;
         if (reported < REPORT_LIMIT)
            $display("%0t: result with nothing owed: row %0d col %0d value %0d last %b err %b",
                     $time, got.out_row, got.out_col, got.out_value, got.is_last,
                     got.dim_error);
         reported++;
         return;
      end
      want = owed_products.pop_front();
      if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
          got.out_value !== want.out_value || got.is_last !== want.is_last ||
          got.dim_error !== want.dim_error) begin
         fail_count++;
         if (reported < REPORT_LIMIT) begin
            $display("%0t: expected row %0d col %0d value %0d last %b err %b", $time,
                     want.out_row, want.out_col, want.out_value, want.is_last,
                     want.dim_error);
            $display("%0t: actual   row %0d col %0d value %0d last %b err %b", $time,
                     got.out_row, got.out_col, got.out_value, got.is_last,
                     got.dim_error);
         end
         reported++;
      end
   endtask

   // Follow every transaction at the clock edge where it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         owed_products.delete();
         a_rows_reg = DIM_RESET;
         a_cols_reg = DIM_RESET;
         b_rows_reg = DIM_RESET;
         b_cols_reg = DIM_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_A_ROWS: a_rows_reg = csr_wdata;
               CSR_A_COLS: a_cols_reg = csr_wdata;
               CSR_B_ROWS: b_rows_reg = csr_wdata;
               CSR_B_COLS: b_cols_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.req_type)
               REQ_LOAD_A:
                  a_elems[req_data.elem_row*MAX_DIM+req_data.elem_col] = req_data.elem_value;
               REQ_LOAD_B:
                  b_elems[req_data.elem_row*MAX_DIM+req_data.elem_col] = req_data.elem_value;
               REQ_START:
                  predict_product();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            compare_result(rsp_data);
      end
      pending_count = owed_products.size();
   end

endmodule

@@ tb/sv/matrix_multiply_engine_top_tb.sv @@
// Testbench top for the matrix multiply engine: drives loads, starts and register
// writes with random idling, and gives the verdict. Depends on mme_pkg,
// matrix_multiply_engine_top and matrix_product_checker.
`timescale 1ns / 1ps

module matrix_multiply_engine_top_tb;
   import mme_pkg::*;

   localparam int MAX_DIM = 8;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS = 230;
   localparam int SETTLE_CYCLES = 16;
   localparam int SILENCE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_A_ROWS;
   logic [DIM_W-1:0] csr_wdata = DIM_RESET;

   int fail_count, pending_count, product_count, dim_error_count;
   int idle_pct, stall_pct, stall_left, silent_cycles;
   int item_count, start_count, setting_count;
   int rows_a, cols_a, rows_b, cols_b;
   bit a_loaded [MAX_DIM*MAX_DIM];
   bit b_loaded [MAX_DIM*MAX_DIM];

   matrix_multiply_engine_top #(
      .MAX_DIM(MAX_DIM)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   matrix_product_checker #(
      .MAX_DIM(MAX_DIM)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending_count),
      .product_count(product_count),
      .dim_error_count(dim_error_count)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Result side backpressure in bursts of random length.
   always @(negedge clock) begin
      if (reset || stall_pct == 0) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         silent_cycles = 0;
      end else begin
         silent_cycles++;
         if (silent_cycles >= SILENCE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results still owed.",
                     SILENCE_LIMIT, pending_count);
            $display("[matrix_multiply_engine_top] ERROR");
            $finish;
         end
      end
   end

   function automatic int effective_dim(input logic [DIM_W-1:0] d);
      if (d == '0)
         return 1;
      if (int'(d) > MAX_DIM)
         return MAX_DIM;
      return int'(d);
   endfunction

   // Mostly small sizes; now and then the larger ones and out of range values.
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return DIM_W'($urandom_range(9, 15));
         2, 3: return DIM_W'($urandom_range(5, 8));
         default: return DIM_W'($urandom_range(1, 4));
      endcase
   endfunction

   // Element values: extremes, zero, full random, and values from minus two to just under two.
   function automatic logic signed [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return '0;
         3, 4: return ELEM_W'($urandom);
         default: return ELEM_W'($urandom_range(0, 16383) - 8192);
      endcase
   endfunction

   // Send one request transaction, possibly after an idle burst.
   task automatic send(input logic [1:0] kind, input int row, input int col,
                       input logic signed [ELEM_W-1:0] value);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_data <= '{req_type: kind, elem_row: IDX_W'(row), elem_col: IDX_W'(col),
                    elem_value: value};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (kind != REQ_UNUSED)
         item_count++;
   endtask

   task automatic load_elem(input logic [1:0] kind, input int row, input int col,
                            input logic signed [ELEM_W-1:0] value);
      send(kind, row, col, value);
      if (kind == REQ_LOAD_A)
         a_loaded[row*MAX_DIM+col] = 1'b1;
      else
         b_loaded[row*MAX_DIM+col] = 1'b1;
   endtask

   // Make sure every element the multiply reads has been loaded, then start it.
   task automatic issue_start();
      if (cols_a == rows_b) begin
         for (int i = 0; i < rows_a; i++)
            for (int k = 0; k < cols_a; k++)
               if (!a_loaded[i*MAX_DIM+k])
                  load_elem(REQ_LOAD_A, i, k, pick_value());
         for (int k = 0; k < rows_b; k++)
            for (int j = 0; j < cols_b; j++)
               if (!b_loaded[k*MAX_DIM+j])
                  load_elem(REQ_LOAD_B, k, j, pick_value());
      end
      send(REQ_START, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_W'($urandom));
      start_count++;
   endtask

   // Stop sending and wait until every owed result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Leaves csr_valid high so that back to back writes keep it asserted.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                           input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
      drain();
      write_reg(CSR_A_ROWS, ar);
      write_reg(CSR_A_COLS, ac);
      write_reg(CSR_B_ROWS, br);
      write_reg(CSR_B_COLS, bc);
      csr_valid <= 1'b0;
      rows_a = effective_dim(ar);
      cols_a = effective_dim(ac);
      rows_b = effective_dim(br);
      cols_b = effective_dim(bc);
      setting_count++;
   endtask

   // Stimulus: directed corner cases, then random settings and load sequences.
   initial begin
      logic [DIM_W-1:0] ar_reg, ac_reg, br_reg, bc_reg;
      int n_items, roll;
      bit quiet;
      idle_pct = 0;
      stall_pct = 0;
      quiet = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single element products: saturation both ways and floor rounding of -1.
      set_dims(4'd1, 4'd1, 4'd1, 4'd1);
      load_elem(REQ_LOAD_A, 0, 0, 16'h7FFF);
      load_elem(REQ_LOAD_B, 0, 0, 16'h7FFF);
      issue_start();
      load_elem(REQ_LOAD_A, 0, 0, 16'h8000);
      issue_start();
      load_elem(REQ_LOAD_B, 0, 0, 16'h8000);
      issue_start();
      load_elem(REQ_LOAD_A, 0, 0, 16'hFFFF);
      load_elem(REQ_LOAD_B, 0, 0, 16'h0001);
      issue_start();

      // The unused request code must leave the stores alone.
      send(REQ_UNUSED, 0, 0, 16'h1234);
      issue_start();

      // Zero dimensions act as one.
      set_dims(4'd0, 4'd0, 4'd0, 4'd0);
      issue_start();

      // Inner dimensions that differ give a single error result.
      set_dims(4'd1, 4'd1, 4'd2, 4'd1);
      issue_start();

      // Two term dot product that overflows, then an outer product.
      set_dims(4'd1, 4'd2, 4'd2, 4'd1);
      load_elem(REQ_LOAD_A, 0, 1, 16'h7FFF);
      load_elem(REQ_LOAD_B, 1, 0, 16'h7FFF);
      issue_start();
      set_dims(4'd2, 4'd1, 4'd1, 4'd3);
      issue_start();

      // Random settings, each with a burst of loads ending in a start.
      while (item_count < TOTAL_ITEMS) begin
         if (!quiet) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 10;
               default: idle_pct = 35;
            endcase
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         if (setting_count == 5) begin
            // Full size, with out of range values that act as the maximum.
            ar_reg = 4'd15;
            ac_reg = 4'd8;
            br_reg = 4'd8;
            bc_reg = 4'd9;
         end else begin
            ar_reg = pick_dim();
            ac_reg = pick_dim();
            bc_reg = pick_dim();
            br_reg = ac_reg;
            if ($urandom_range(0, 9) == 0) begin
               do br_reg = pick_dim(); while (effective_dim(br_reg) == effective_dim(ac_reg));
            end else if ($urandom_range(0, 3) == 0) begin
               // Different register value with the same effective size.
               if (effective_dim(ac_reg) == MAX_DIM)
                  br_reg = DIM_W'($urandom_range(MAX_DIM, 15));
               else if (effective_dim(ac_reg) == 1)
                  br_reg = DIM_W'($urandom_range(0, 1));
            end
         end
         set_dims(ar_reg, ac_reg, br_reg, bc_reg);

         n_items = $urandom_range(2, 8);
         for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
               send(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                    ELEM_W'($urandom));
            end else if (roll < 14) begin
               issue_start();
            end else if (roll < 57) begin
               load_elem(REQ_LOAD_A, $urandom_range(0, rows_a - 1),
                         $urandom_range(0, cols_a - 1), pick_value());
            end else begin
               load_elem(REQ_LOAD_B, $urandom_range(0, rows_b - 1),
                         $urandom_range(0, cols_b - 1), pick_value());
            end
         end
         // Sometimes hold off until the block has delivered everything.
         if ($urandom_range(0, 4) == 0)
            drain();
         issue_start();

         // The last part of the run goes without any idling.
         if (item_count >= TOTAL_ITEMS * 4 / 5) begin
            quiet = 1'b1;
            idle_pct = 0;
            stall_pct = 0;
         end
      end

      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d loads and starts (%0d starts) across %0d dimension settings.",
               item_count, start_count, setting_count);
      $display("Checked %0d product elements and %0d dimension error results.",
               product_count, dim_error_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[matrix_multiply_engine_top] OK");
      else
         $display("[matrix_multiply_engine_top] ERROR");
      $finish;
   end

endmodule
